/* rtl/core/jsu_pkg.sv */
// Package for the JSON string unescape block: transfer payload types,
// result kind codes, decoder state and the hex digit and escape byte helpers. No dependencies.
`default_nettype none

package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last;
	} out_item_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U         = 8'h75;

	localparam int MaxResults = 3;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  hex_cnt;
		logic [15:0] code_point;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{MODE_IDLE, 2'd0, 16'd0};

	typedef struct packed {
		logic [1:0]                     cnt;
		out_item_t [MaxResults-1:0]     ent;
	} res_group_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_value(input logic [7:0] b);
		hex_digit_t r;
		r = '{1'b0, 4'd0};
		if (b inside {[8'h30:8'h39]}) begin
			r.ok = 1'b1;
			r.value = b[3:0];
		end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r.ok = 1'b1;
			r.value = 4'(b[2:0] + 3'd1) + 4'd8;
		end
		return r;
	endfunction

	function automatic logic [7:0] escape_byte(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h62: r = 8'h08;
			8'h66: r = 8'h0C;
			8'h6E: r = 8'h0A;
			8'h72: r = 8'h0D;
			8'h74: r = 8'h09;
			default: r = b;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/jsu_decode.sv */
// Next-state and result-group logic for one input byte of the unescape block.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode
	import jsu_pkg::*;
(
	input  dec_state_t st,
	input  in_item_t   item,
	output dec_state_t nxt,
	output res_group_t grp
);

	hex_digit_t  hv;
	logic [15:0] cp;
	logic [7:0]  b;

	assign b  = item.in_byte;
	assign hv = hex_value(b);
	assign cp = {st.code_point[11:0], hv.value};

	always_comb begin
		nxt = st;
		grp = '0;
		if (item.end_of_data) begin
			grp.cnt = 2'd1;
			grp.ent[0].kind = KIND_ERROR;
			nxt = STATE_RESET;
		end else begin
			case (st.mode)
				MODE_IDLE: begin
					if (b == CH_QUOTE) begin
						nxt.mode = MODE_STR;
					end else begin
						grp.cnt = 2'd1;
						grp.ent[0].kind = KIND_ERROR;
					end
				end
				MODE_STR: begin
					if (b == CH_QUOTE) begin
						grp.cnt = 2'd1;
						grp.ent[0].kind = KIND_DONE;
						nxt.mode = MODE_IDLE;
					end else if (b == CH_BACKSLASH) begin
						nxt.mode = MODE_ESC;
					end else begin
						grp.cnt = 2'd1;
						grp.ent[0].out_byte = b;
						grp.ent[0].kind = KIND_BYTE;
					end
				end
				MODE_ESC: begin
					if (b == CH_U) begin
						nxt.mode = MODE_HEX;
						nxt.hex_cnt = 2'd0;
						nxt.code_point = 16'd0;
					end else begin
						grp.cnt = 2'd1;
						grp.ent[0].out_byte = escape_byte(b);
						grp.ent[0].kind = KIND_BYTE;
						nxt.mode = MODE_STR;
					end
				end
				MODE_HEX: begin
					if (!hv.ok) begin
						grp.cnt = 2'd1;
						grp.ent[0].kind = KIND_ERROR;
						nxt = STATE_RESET;
					end else if (st.hex_cnt != 2'd3) begin
						nxt.hex_cnt = st.hex_cnt + 2'd1;
						nxt.code_point = cp;
					end else begin
						nxt.mode = MODE_STR;
						nxt.hex_cnt = 2'd0;
						nxt.code_point = 16'd0;
						grp.ent[0].kind = KIND_BYTE;
						grp.ent[1].kind = KIND_BYTE;
						grp.ent[2].kind = KIND_BYTE;
						if (cp < 16'h0080) begin
							grp.cnt = 2'd1;
							grp.ent[0].out_byte = cp[7:0];
						end else if (cp < 16'h0800) begin
							grp.cnt = 2'd2;
							grp.ent[0].out_byte = 8'hC0 | {3'd0, cp[10:6]};
							grp.ent[1].out_byte = 8'h80 | {2'd0, cp[5:0]};
						end else begin
							grp.cnt = 2'd3;
							grp.ent[0].out_byte = 8'hE0 | {4'd0, cp[15:12]};
							grp.ent[1].out_byte = 8'h80 | {2'd0, cp[11:6]};
							grp.ent[2].out_byte = 8'h80 | {2'd0, cp[5:0]};
						end
					end
				end
				default: begin
					nxt = STATE_RESET;
				end
			endcase
		end
		case (grp.cnt)
			2'd1: grp.ent[0].last = 1'b1;
			2'd2: grp.ent[1].last = 1'b1;
			2'd3: grp.ent[2].last = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/json_string_unescape.sv */
// Top level of the JSON string unescape block: decoder state and result register.
// Depends on jsu_pkg and jsu_decode.
`default_nettype none

//  channel | direction | handshake             | payload
//  raw     | in        | raw_valid, raw_stall  | in_item_t  (in_byte, end_of_data)
//  dec     | out       | dec_valid, dec_stall  | out_item_t (out_byte, kind, last)
//
// One raw byte is taken per cycle unless raw_stall holds it. A \u escape that
// expands to two or three UTF-8 bytes holds the raw side while the result
// register drains. Results appear in the cycle after their byte is taken.
// Reset clears the decoder to idle and empties the result register.
// raw_stall rises only while results from an earlier byte still wait.

module json_string_unescape
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      raw_valid,
	output logic      raw_stall,
	input  in_item_t  raw_data,
	output logic      dec_valid,
	input  logic      dec_stall,
	output out_item_t dec_data
);

	dec_state_t                 st_q;
	dec_state_t                 st_nxt;
	res_group_t                 grp_nxt;
	logic [1:0]                 rem_q;
	out_item_t [MaxResults-1:0] ent_q;
	logic                       take;
	logic                       pop;

	jsu_decode u_decode (
		.st   (st_q),
		.item (raw_data),
		.nxt  (st_nxt),
		.grp  (grp_nxt)
	);

	assign dec_valid = (rem_q != 2'd0);
	assign dec_data  = ent_q[0];
	assign pop       = dec_valid && !dec_stall;
	assign raw_stall = (rem_q > 2'd1) || ((rem_q == 2'd1) && dec_stall);
	assign take      = raw_valid && !raw_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= STATE_RESET;
			rem_q <= 2'd0;
		end else begin
			if (take) begin
				st_q  <= st_nxt;
				rem_q <= grp_nxt.cnt;
			end else if (pop) begin
				rem_q <= rem_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q <= grp_nxt.ent;
		end else if (pop) begin
			ent_q <= {out_item_t'('0), ent_q[MaxResults-1:1]};
		end
	end

	a_eod_error: assert property (@(posedge clk) disable iff (!arst_n)
		take && raw_data.end_of_data |=> dec_valid && dec_data.kind == KIND_ERROR
			&& dec_data.last && st_q.mode == MODE_IDLE)
		else $error("end of data did not give a single error result");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_data.kind != KIND_BYTE |-> dec_data.last)
		else $error("completion or error result not marked last");

	a_hex_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.hex_cnt != 2'd0 |-> st_q.mode == MODE_HEX)
		else $error("hex digit count set outside a unicode escape");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q > 2'd1 |-> raw_stall)
		else $error("raw byte taken while several results wait");

endmodule

`default_nettype wire
